/* hdl/direct_mapped_writeback_cache_unit_macros.svh */
// assertion macros for the direct mapped write-back cache
`ifndef DIRECT_MAPPED_WRITEBACK_CACHE_UNIT_MACROS_SVH
`define DIRECT_MAPPED_WRITEBACK_CACHE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked on every rising clk edge out of reset
`define DMWC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dmwc check failed");
// next-cycle implication
`define DMWC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dmwc check failed");
`else
`define DMWC_ASSERT_SAME(label, ante, cons)
`define DMWC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* hdl/dmwc_pkg.sv */
// shared constants and types for the direct mapped write-back cache
`timescale 1ns / 1ps
package dmwc_pkg;
    localparam int ADDR_BITS      = 16;
    localparam int LINES          = 64;
    localparam int BYTES_PER_LINE = 8;
    localparam int OFFSET_BITS    = $clog2(BYTES_PER_LINE);
    localparam int INDEX_BITS     = $clog2(LINES);
    localparam int TAG_BITS       = ADDR_BITS - INDEX_BITS - OFFSET_BITS;
    localparam int BLOCK_BITS     = ADDR_BITS - OFFSET_BITS;
    localparam int LINE_BITS      = BYTES_PER_LINE * 8;
    localparam int MEM_DEPTH      = 2 ** BLOCK_BITS;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef struct packed {
        logic                  dirty;
        logic [TAG_BITS-1:0]   tag;
        logic [LINE_BITS-1:0]  data;
    } line_t;

    // controller to datapath
    typedef struct packed {
        logic capture;   // latch item, read line store
        logic access;    // finish a hit
        logic evict;     // miss: write back victim, read new block
        logic refill;    // finish a miss with fetched block
        logic clear;     // one step of the backing memory clearing pass
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic hit;
        logic clr_last;
    } status_t;
endpackage

/* hdl/dmwc_ram.sv */
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
module dmwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

/* hdl/dmwc_ctrl.sv */
// cache controller state machine
`timescale 1ns / 1ps
module dmwc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  dmwc_pkg::status_t status,
    output dmwc_pkg::ctl_t    ctl,
    output logic              busy
);
    import dmwc_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR  = 4'b0001,
        S_IDLE   = 4'b0010,
        S_LOOKUP = 4'b0100,
        S_FILL   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                ctl.clear = 1'b1;
                if (status.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.capture = 1'b1;
                    state_next  = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                if (status.hit)
                begin
                    ctl.access = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    ctl.evict  = 1'b1;
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                ctl.refill = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
endmodule

/* hdl/dmwc_dp.sv */
// cache datapath: line store, backing memory, item and result registers
`timescale 1ns / 1ps
module dmwc_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  dmwc_pkg::ctl_t                     ctl,
    output dmwc_pkg::status_t                  status,
    input  logic                               cmd,
    input  logic [dmwc_pkg::ADDR_BITS-1:0]     address,
    input  logic [7:0]                         write_byte,
    output logic                               done,
    output logic [dmwc_pkg::ADDR_BITS-1:0]     echo_address,
    output logic [dmwc_pkg::LINE_BITS-1:0]     line_bytes,
    output logic                               hit,
    output logic                               was_dirty
);
    import dmwc_pkg::*;

    logic                   cmd_reg;
    logic [ADDR_BITS-1:0]   address_reg;
    logic [7:0]             wbyte_reg;
    logic [LINES-1:0]       valid_reg;
    logic [BLOCK_BITS-1:0]  clr_cnt_reg;

    logic                   done_reg;
    logic [ADDR_BITS-1:0]   echo_address_reg;
    logic [LINE_BITS-1:0]   line_bytes_reg;
    logic                   hit_reg;
    logic                   was_dirty_reg;

    logic [INDEX_BITS-1:0]  idx;
    logic [TAG_BITS-1:0]    tag;
    logic [OFFSET_BITS-1:0] off;
    logic [BLOCK_BITS-1:0]  block;

    line_t                  line_rd;
    line_t                  stored;
    line_t                  line_wr;
    logic                   line_wr_en;
    logic                   tag_match;

    logic                   mem_wr_en;
    logic [BLOCK_BITS-1:0]  mem_wr_addr;
    logic [LINE_BITS-1:0]   mem_wr_data;
    logic [LINE_BITS-1:0]   mem_rd_data;

    logic [LINE_BITS-1:0]   base_data;
    logic [LINE_BITS-1:0]   merged_data;
    logic                   finish;
    logic                   done_next;

    assign idx   = address_reg[OFFSET_BITS +: INDEX_BITS];
    assign tag   = address_reg[ADDR_BITS-1 -: TAG_BITS];
    assign off   = address_reg[OFFSET_BITS-1:0];
    assign block = address_reg[ADDR_BITS-1 -: BLOCK_BITS];

    // a line never written reads as tag 0, clean, zero data
    assign stored    = valid_reg[idx] ? line_rd : '0;
    assign tag_match = (stored.tag == tag);

    assign status.hit      = tag_match;
    assign status.clr_last = &clr_cnt_reg;

    // victim write-back and new block read share the same cycle; the two
    // block addresses differ because the tags differ
    assign mem_wr_en   = (ctl.evict && stored.dirty) || ctl.clear;
    assign mem_wr_addr = ctl.clear ? clr_cnt_reg : {stored.tag, idx};
    assign mem_wr_data = ctl.clear ? '0 : stored.data;

    assign base_data = ctl.refill ? mem_rd_data : stored.data;

    always_comb
    begin
        merged_data = base_data;
        for (int b = 0; b < BYTES_PER_LINE; b++)
        begin
            if (off == OFFSET_BITS'(b))
            begin
                merged_data[8*b +: 8] = wbyte_reg;
            end
        end
    end

    assign finish     = ctl.access || ctl.refill;
    assign line_wr_en = (ctl.access && (cmd_reg == CMD_WRITE)) || ctl.refill;
    assign done_next  = finish && (cmd_reg == CMD_READ);

    always_comb
    begin
        line_wr.dirty = (cmd_reg == CMD_WRITE);
        line_wr.tag   = tag;
        line_wr.data  = (cmd_reg == CMD_WRITE) ? merged_data : base_data;
    end

    dmwc_ram #(
        .WIDTH ($bits(line_t)),
        .DEPTH (LINES)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (line_wr_en),
        .wr_addr (idx),
        .wr_data (line_wr),
        .rd_en   (ctl.capture),
        .rd_addr (address[OFFSET_BITS +: INDEX_BITS]),
        .rd_data (line_rd)
    );

    dmwc_ram #(
        .WIDTH (LINE_BITS),
        .DEPTH (MEM_DEPTH)
    ) u_backing_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (ctl.evict),
        .rd_addr (block),
        .rd_data (mem_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (line_wr_en)
            begin
                valid_reg[idx] <= 1'b1;
            end
            if (ctl.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg     <= cmd;
            address_reg <= address;
            wbyte_reg   <= write_byte;
        end
        if (done_next)
        begin
            echo_address_reg <= address_reg;
            line_bytes_reg   <= base_data;
            hit_reg          <= tag_match;
            was_dirty_reg    <= stored.dirty;
        end
    end

    assign done         = done_reg;
    assign echo_address = echo_address_reg;
    assign line_bytes   = line_bytes_reg;
    assign hit          = hit_reg;
    assign was_dirty    = was_dirty_reg;
endmodule

/* hdl/direct_mapped_writeback_cache_unit.sv */
// top level of the direct mapped write-back write-allocate cache
//
//  channel  | handshake            | fields
//  ---------+----------------------+-----------------------------------------
//  item in  | start high, busy low | cmd, address, write_byte
//  result   | done strobe, 1 cycle | echo_address, line_bytes, hit, was_dirty
//
// a hit passes the lookup state back to idle, a miss also the fill state:
// the line store read is registered, and a miss adds a backing memory
// access (victim write-back and block fetch use the two ports together)
// reads give a result with done in the cycle busy drops; writes give none
// after reset busy stays high while all 8192 rows of backing memory are
// cleared, one row a cycle
// the receiver cannot stall: each result is shown for exactly one cycle
`timescale 1ns / 1ps
`include "direct_mapped_writeback_cache_unit_macros.svh"
module direct_mapped_writeback_cache_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           cmd,
    input  logic [dmwc_pkg::ADDR_BITS-1:0] address,
    input  logic [7:0]                     write_byte,
    output logic                           done,
    output logic [dmwc_pkg::ADDR_BITS-1:0] echo_address,
    output logic [dmwc_pkg::LINE_BITS-1:0] line_bytes,
    output logic                           hit,
    output logic                           was_dirty
);
    import dmwc_pkg::*;

    ctl_t    ctl;
    status_t status;

    dmwc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .ctl    (ctl),
        .busy   (busy)
    );

    dmwc_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .status       (status),
        .cmd          (cmd),
        .address      (address),
        .write_byte   (write_byte),
        .done         (done),
        .echo_address (echo_address),
        .line_bytes   (line_bytes),
        .hit          (hit),
        .was_dirty    (was_dirty)
    );

    // an accepted item makes the block busy in the cycle after
    `DMWC_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    // results never come back to back
    `DMWC_ASSERT_NEXT(a_done_single, done, !done)
    // a result only follows a cycle of work
    `DMWC_ASSERT_SAME(a_done_after_work, done, $past(busy))
    // a miss never reports the line as hit in the fill step
    `DMWC_ASSERT_SAME(a_fill_is_miss, ctl.refill, !status.hit)
endmodule

/* dv/tb.sv */
// self-checking testbench for the direct mapped write-back write-allocate cache
`timescale 1ns / 1ps
module tb;
    import dmwc_pkg::*;

    typedef struct packed {
        logic [ADDR_BITS-1:0] addr;
        logic [LINE_BITS-1:0] line;
        logic                 hit;
        logic                 dirty;
    } read_result_t;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 start      = 1'b0;
    logic                 cmd        = CMD_READ;
    logic [ADDR_BITS-1:0] address    = '0;
    logic [7:0]           write_byte = '0;
    logic                 busy;
    logic                 done;
    logic [ADDR_BITS-1:0] echo_address;
    logic [LINE_BITS-1:0] line_bytes;
    logic                 hit;
    logic                 was_dirty;

    // shadow copy of the cache lines and of the backing memory
    logic [TAG_BITS-1:0]  shadow_tag   [LINES];
    logic                 shadow_dirty [LINES];
    logic [LINE_BITS-1:0] shadow_data  [LINES];
    logic [LINE_BITS-1:0] shadow_mem   [MEM_DEPTH];
    read_result_t         pending_reads [$];

    int error_count     = 0;
    int read_count      = 0;
    int write_count     = 0;
    int hit_count       = 0;
    int writeback_count = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    direct_mapped_writeback_cache_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .address      (address),
        .write_byte   (write_byte),
        .done         (done),
        .echo_address (echo_address),
        .line_bytes   (line_bytes),
        .hit          (hit),
        .was_dirty    (was_dirty)
    );

    function automatic logic [ADDR_BITS-1:0] make_addr(
        logic [TAG_BITS-1:0] tg, logic [INDEX_BITS-1:0] idx, logic [OFFSET_BITS-1:0] off);
        return {tg, idx, off};
    endfunction

    // updates the shadow cache for one accepted access, queues the read result
    function automatic void track_access(
        logic op, logic [ADDR_BITS-1:0] a, logic [7:0] wb);
        logic [OFFSET_BITS-1:0] off;
        logic [INDEX_BITS-1:0]  idx;
        logic [TAG_BITS-1:0]    tg;
        logic                   is_hit;
        logic                   old_dirty;
        read_result_t           res;
        off       = a[OFFSET_BITS-1:0];
        idx       = a[OFFSET_BITS +: INDEX_BITS];
        tg        = a[ADDR_BITS-1 -: TAG_BITS];
        is_hit    = (shadow_tag[idx] == tg);
        old_dirty = shadow_dirty[idx];
        if (is_hit)
        begin
            hit_count++;
        end
        else
        begin
            if (old_dirty)
            begin
                shadow_mem[{shadow_tag[idx], idx}] = shadow_data[idx];
                writeback_count++;
            end
            shadow_dirty[idx] = 1'b0;
            shadow_tag[idx]   = tg;
            shadow_data[idx]  = shadow_mem[{tg, idx}];
        end
        if (op == CMD_WRITE)
        begin
            shadow_data[idx][off*8 +: 8] = wb;
            shadow_dirty[idx]            = 1'b1;
            write_count++;
        end
        else
        begin
            res.addr  = a;
            res.line  = shadow_data[idx];
            res.hit   = is_hit;
            res.dirty = old_dirty;
            pending_reads.push_back(res);
            read_count++;
        end
    endfunction

    // start stays high after acceptance; the next negedge either drives a new item or drops it
    task automatic send_item(logic op, logic [ADDR_BITS-1:0] a, logic [7:0] wb);
        @(negedge clk);
        start      <= 1'b1;
        cmd        <= op;
        address    <= a;
        write_byte <= wb;
        do
            @(posedge clk);
        while (busy);
        track_access(op, a, wb);
    endtask

    // idle cycles with junk on the item fields
    task automatic pause_sender(int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start      <= 1'b0;
            cmd        <= 1'($urandom);
            address    <= ADDR_BITS'($urandom);
            write_byte <= 8'($urandom);
        end
    endtask

    task automatic wait_reads_drained();
        pause_sender(1);
        while (pending_reads.size() != 0)
            @(negedge clk);
    endtask

    always @(posedge clk)
    begin : check_results
        read_result_t want;
        if (rst_n && done)
        begin
            if (pending_reads.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result: addr %h line %h hit %b dirty %b",
                             echo_address, line_bytes, hit, was_dirty);
            end
            else
            begin
                want = pending_reads.pop_front();
                if (echo_address !== want.addr || line_bytes !== want.line ||
                    hit !== want.hit || was_dirty !== want.dirty)
                begin
                    error_count++;
                    if (error_count <= 10)
                    begin
                        $display("mismatch expected: addr %h line %h hit %b dirty %b",
                                 want.addr, want.line, want.hit, want.dirty);
                        $display("           actual: addr %h line %h hit %b dirty %b",
                                 echo_address, line_bytes, hit, was_dirty);
                    end
                end
            end
        end
    end

    // lines start at tag 0 with zero data, so tag 0 hits and anything else misses
    task automatic test_reset_state();
        send_item(CMD_READ, make_addr(0, 0, 0), 8'h00);
        send_item(CMD_READ, make_addr(0, 63, 7), 8'hFF);
        send_item(CMD_READ, 16'hFFFF, 8'h00);
        send_item(CMD_READ, make_addr(127, 0, 0), 8'h00);
    endtask

    task automatic test_write_hits();
        send_item(CMD_WRITE, make_addr(0, 1, 0), 8'hFF);
        send_item(CMD_WRITE, make_addr(0, 1, 7), 8'h00);
        send_item(CMD_WRITE, make_addr(0, 1, 7), 8'hFF);
        send_item(CMD_WRITE, make_addr(0, 1, 4), 8'h5A);
        send_item(CMD_READ,  make_addr(0, 1, 2), 8'h00);
    endtask

    task automatic test_evictions();
        send_item(CMD_WRITE, make_addr(5, 10, 3), 8'hA5);
        send_item(CMD_WRITE, make_addr(5, 10, 7), 8'h3C);
        send_item(CMD_READ,  make_addr(9, 10, 0), 8'h00);   // dirty victim on a read miss
        send_item(CMD_READ,  make_addr(5, 10, 1), 8'h00);   // refetch of written-back data
        send_item(CMD_WRITE, make_addr(9, 10, 0), 8'h01);
        send_item(CMD_WRITE, make_addr(127, 10, 0), 8'hFE); // dirty victim on a write miss
        send_item(CMD_READ,  make_addr(9, 10, 5), 8'h00);
        send_item(CMD_READ,  make_addr(127, 10, 0), 8'h00);
        send_item(CMD_READ,  make_addr(0, 1, 0), 8'h00);
    endtask

    task automatic test_random_traffic(int n_items);
        logic [TAG_BITS-1:0]   tag_pool [4];
        logic [INDEX_BITS-1:0] idx_base;
        logic [ADDR_BITS-1:0]  a;
        logic [7:0]            wb;
        logic                  op;
        bit                    idle_on;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 50 == 0)
            begin
                foreach (tag_pool[k])
                    tag_pool[k] = TAG_BITS'($urandom);
                idx_base = INDEX_BITS'($urandom);
                idle_on  = ($urandom_range(0, 3) != 0) && (i < n_items - 200);
            end
            if (i == n_items / 2)
                wait_reads_drained();
            // mostly a small working set so lines get reused, evicted and refetched
            if ($urandom_range(0, 9) < 2)
                a = ADDR_BITS'($urandom);
            else
                a = make_addr(tag_pool[$urandom_range(0, 3)],
                              idx_base + INDEX_BITS'($urandom_range(0, 3)),
                              OFFSET_BITS'($urandom));
            case ($urandom_range(0, 7))
                0:       wb = 8'h00;
                1:       wb = 8'hFF;
                default: wb = 8'($urandom);
            endcase
            op = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
            send_item(op, a, wb);
            if (idle_on && $urandom_range(0, 3) == 0)
                pause_sender($urandom_range(1, 8));
        end
    endtask

    initial
    begin
        foreach (shadow_tag[k])
        begin
            shadow_tag[k]   = '0;
            shadow_dirty[k] = 1'b0;
            shadow_data[k]  = '0;
        end
        foreach (shadow_mem[k])
            shadow_mem[k] = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_write_hits();
        test_evictions();
        test_random_traffic(1650);

        wait_reads_drained();
        pause_sender(12);
        $display("covered %0d reads and %0d writes: %0d hits, %0d dirty write-backs",
                 read_count, write_count, hit_count, writeback_count);
        $display("%0d result errors", error_count);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d reads outstanding", pending_reads.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
